[rtl/cpt_pkg.sv]
// Shared types, widths and codes of the circle/point time-of-impact pipeline.
package cpt_pkg;

  localparam int TW           = 31;
  localparam logic [TW-1:0] TMAX = 31'h7FFF_FFFF;
  localparam logic [30:0] RADIUS_RESET = 31'd65536;

  // Internal widths, sized for exact results on full-range inputs.
  localparam int M_W        = 64;   // |v.d|
  localparam int A_W        = 64;   // v.v
  localparam int DD_W       = 65;   // d.d and d.d - r*r
  localparam int SQ_W       = 130;  // 4*(m*m - a*c)
  localparam int ROOT_STEPS = 65;   // one result bit of the square root per stage
  localparam int NORM_STEPS = 15;   // one bit of each normal magnitude per stage
  localparam int NK_W       = 15;
  localparam int NP_W       = 96;
  localparam int NQ_W       = 80;
  localparam int DEN_W      = 65;
  localparam int REM_W      = 90;   // (2m - s) shifted by up to 24 fraction bits
  localparam int CMP_W      = 96;
  localparam int DIV_STEPS  = 31;

  typedef enum logic [2:0] {
    ST_HIT     = 3'd0,
    ST_STATIC  = 3'd1,
    ST_AWAY    = 3'd2,
    ST_MISS    = 3'd3,
    ST_OVERLAP = 3'd4
  } status_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [TW-1:0]      time_to_contact;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
  } out_item_t;

  typedef struct packed {
    logic            valid;
    status_t         status;
    logic [M_W-1:0]  m;
    logic [A_W-1:0]  a;
    logic [DD_W-1:0] c;
    logic [DD_W-1:0] dd;
    logic [63:0]     usq_x;
    logic [63:0]     usq_y;
    logic            sx;
    logic            sy;
    logic [31:0]     tx;
    logic [31:0]     ty;
  } coef_t;

  typedef struct packed {
    logic [NK_W-1:0] k;
    logic [NP_W-1:0] p;
    logic [NQ_W-1:0] q;
  } nrm_t;

  typedef struct packed {
    logic            valid;
    status_t         status;
    logic [M_W-1:0]  m;
    logic [A_W-1:0]  a;
    logic [DD_W-1:0] dd;
    logic [63:0]     usq_x;
    logic [63:0]     usq_y;
    logic            sx;
    logic            sy;
    logic [31:0]     tx;
    logic [31:0]     ty;
    logic [SQ_W-1:0] rad;
    logic [SQ_W-1:0] res;
    nrm_t            nx;
    nrm_t            ny;
  } root_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [REM_W-1:0] num;
    logic [CMP_W-1:0] lim;
    logic [DEN_W-1:0] den;
    logic             dd_zero;
    logic [NK_W-1:0]  kx;
    logic [NK_W-1:0]  ky;
    logic             sx;
    logic             sy;
    logic [31:0]      tx;
    logic [31:0]      ty;
  } prep_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [TW-1:0]    t;
    logic             sat;
    logic             dd_zero;
    logic [NK_W-1:0]  kx;
    logic [NK_W-1:0]  ky;
    logic             sx;
    logic             sy;
    logic [31:0]      tx;
    logic [31:0]      ty;
  } div_t;

endpackage

[rtl/cpt_chan_if.sv]
// Valid/ready channel interface carrying one payload of a given type.
interface cpt_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/cpt_coef.sv]
// Front stages: offset d, first products, and the sums a, |v.d|, d.d and c.
module cpt_coef (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               item_valid,
  input  cpt_pkg::in_item_t  item,
  input  logic [30:0]        radius,
  output cpt_pkg::coef_t     coef
);
  import cpt_pkg::*;

  logic               s1_valid_r;
  logic signed [32:0] s1_dx_r, s1_dy_r;
  logic signed [31:0] s1_vx_r, s1_vy_r;
  logic [31:0]        s1_tx_r, s1_ty_r;

  logic               s2_valid_r;
  logic [63:0]        s2_vxx_r, s2_vyy_r, s2_usqx_r, s2_usqy_r;
  logic signed [63:0] s2_p1_r, s2_p2_r;
  logic [61:0]        s2_r2_r;
  logic               s2_sx_r, s2_sy_r;
  logic [31:0]        s2_tx_r, s2_ty_r;

  coef_t              coef_r, coef_nxt;

  logic signed [63:0] vxx, vyy, p1, p2;
  logic [32:0]        adx, ady;
  logic [31:0]        udx, udy;
  logic signed [64:0] psum;
  logic [64:0]        pmag;
  logic [65:0]        cdiff;

  // Stage 1: offset from the target.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_dx_r <= 33'(item.pos_x) - 33'(item.target_x);
      s1_dy_r <= 33'(item.pos_y) - 33'(item.target_y);
      s1_vx_r <= item.vel_x;
      s1_vy_r <= item.vel_y;
      s1_tx_r <= item.target_x;
      s1_ty_r <= item.target_y;
    end
  end

  // Stage 2: one multiplier per product.
  always_comb begin
    adx = s1_dx_r[32] ? 33'(-s1_dx_r) : 33'(s1_dx_r);
    ady = s1_dy_r[32] ? 33'(-s1_dy_r) : 33'(s1_dy_r);
    udx = adx[31:0];
    udy = ady[31:0];
    vxx = s1_vx_r * s1_vx_r;
    vyy = s1_vy_r * s1_vy_r;
    p1  = s1_vx_r * s1_dx_r;
    p2  = s1_vy_r * s1_dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_vxx_r  <= 64'(vxx);
      s2_vyy_r  <= 64'(vyy);
      s2_p1_r   <= p1;
      s2_p2_r   <= p2;
      s2_usqx_r <= 64'(udx) * 64'(udx);
      s2_usqy_r <= 64'(udy) * 64'(udy);
      s2_r2_r   <= 62'(radius) * 62'(radius);
      s2_sx_r   <= s1_dx_r[32];
      s2_sy_r   <= s1_dy_r[32];
      s2_tx_r   <= s1_tx_r;
      s2_ty_r   <= s1_ty_r;
    end
  end

  // Stage 3: sums and the early status decisions.
  always_comb begin
    psum  = 65'(s2_p1_r) + 65'(s2_p2_r);
    pmag  = psum[64] ? 65'(-psum) : 65'(psum);
    cdiff = 66'(s2_usqx_r) + 66'(s2_usqy_r) - 66'(s2_r2_r);

    coef_nxt       = '0;
    coef_nxt.valid = s2_valid_r;
    coef_nxt.a     = s2_vxx_r + s2_vyy_r;
    coef_nxt.m     = pmag[M_W-1:0];
    coef_nxt.dd    = 65'(s2_usqx_r) + 65'(s2_usqy_r);
    coef_nxt.c     = cdiff[DD_W-1:0];
    coef_nxt.usq_x = s2_usqx_r;
    coef_nxt.usq_y = s2_usqy_r;
    coef_nxt.sx    = s2_sx_r;
    coef_nxt.sy    = s2_sy_r;
    coef_nxt.tx    = s2_tx_r;
    coef_nxt.ty    = s2_ty_r;
    if (coef_nxt.a == '0) begin
      coef_nxt.status = ST_STATIC;
    end else if (!psum[64] && psum != '0) begin
      coef_nxt.status = ST_AWAY;
    end else if (cdiff[65]) begin
      coef_nxt.status = ST_OVERLAP;
    end else begin
      coef_nxt.status = ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r.valid <= 1'b0;
    end else if (en) begin
      coef_r <= coef_nxt;
    end
  end

  assign coef = coef_r;

endmodule

[rtl/cpt_disc.sv]
// Discriminant stages: m*m and a*c from 32-bit partial products, then 4*(m*m - a*c).
module cpt_disc (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cpt_pkg::coef_t coef,
  output cpt_pkg::root_t root
);
  import cpt_pkg::*;

  coef_t        s4_side_r, s5_side_r, s6_side_r;
  logic [63:0]  s4_mll_r, s4_mlh_r, s4_mhh_r, s4_cal_r, s4_cah_r;
  logic [64:0]  s4_chl_r, s4_chh_r;
  logic [127:0] s5_msq_r, s6_msq_r;
  logic [95:0]  s5_aclo_r;
  logic [96:0]  s5_achi_r;
  logic [129:0] s6_ac_r;
  root_t        root_r, root_nxt;
  logic [129:0] diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_side_r.valid <= 1'b0;
      s5_side_r.valid <= 1'b0;
      s6_side_r.valid <= 1'b0;
      root_r.valid    <= 1'b0;
    end else if (en) begin
      s4_side_r <= coef;
      s5_side_r <= s4_side_r;
      s6_side_r <= s5_side_r;
      root_r    <= root_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Partial products.
      s4_mll_r  <= 64'(coef.m[31:0])  * 64'(coef.m[31:0]);
      s4_mlh_r  <= 64'(coef.m[31:0])  * 64'(coef.m[63:32]);
      s4_mhh_r  <= 64'(coef.m[63:32]) * 64'(coef.m[63:32]);
      s4_cal_r  <= 64'(coef.c[31:0])  * 64'(coef.a[31:0]);
      s4_cah_r  <= 64'(coef.c[31:0])  * 64'(coef.a[63:32]);
      s4_chl_r  <= 65'(coef.c[64:32]) * 65'(coef.a[31:0]);
      s4_chh_r  <= 65'(coef.c[64:32]) * 65'(coef.a[63:32]);
      // Column sums.
      s5_msq_r  <= {s4_mhh_r, s4_mll_r} + (128'(s4_mlh_r) << 33);
      s5_aclo_r <= 96'(s4_cal_r) + (96'(s4_cah_r) << 32);
      s5_achi_r <= 97'(s4_chl_r) + (97'(s4_chh_r) << 32);
      s6_msq_r  <= s5_msq_r;
      s6_ac_r   <= 130'(s5_aclo_r) + (130'(s5_achi_r) << 32);
    end
  end

  always_comb begin
    diff            = 130'(s6_msq_r) - s6_ac_r;
    root_nxt        = '0;
    root_nxt.valid  = s6_side_r.valid;
    root_nxt.status = s6_side_r.status;
    root_nxt.m      = s6_side_r.m;
    root_nxt.a      = s6_side_r.a;
    root_nxt.dd     = s6_side_r.dd;
    root_nxt.usq_x  = s6_side_r.usq_x;
    root_nxt.usq_y  = s6_side_r.usq_y;
    root_nxt.sx     = s6_side_r.sx;
    root_nxt.sy     = s6_side_r.sy;
    root_nxt.tx     = s6_side_r.tx;
    root_nxt.ty     = s6_side_r.ty;
    root_nxt.rad    = diff << 2;
    if (s6_side_r.status == ST_HIT && 130'(s6_msq_r) < s6_ac_r) begin
      root_nxt.status = ST_MISS;
    end
  end

  assign root = root_r;

endmodule

[rtl/cpt_root_stage.sv]
// One square-root digit stage, with one normal-magnitude bit per axis in the early stages.
module cpt_root_stage #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  cpt_pkg::root_t d_in,
  output cpt_pkg::root_t d_out
);
  import cpt_pkg::*;

  localparam int RBIT = SQ_W - 2 - 2 * STEP;
  localparam int NBIT = (STEP < NORM_STEPS) ? NORM_STEPS - 1 - STEP : 0;

  root_t         stage_r, stage_nxt;
  logic [SQ_W:0] trial;

  // Largest k with dd*k*k <= usq << 28, one bit at a time, keeping dd*k*k and dd*k.
  function automatic nrm_t nrm_step(nrm_t s, logic [DD_W-1:0] dd, logic [63:0] usq);
    logic [NP_W:0] sum;
    logic [NP_W:0] rhs;
    nrm_t          r;
    r   = s;
    sum = (NP_W + 1)'(s.p) + ((NP_W + 1)'(s.q) << (NBIT + 1))
        + ((NP_W + 1)'(dd) << (2 * NBIT));
    rhs = (NP_W + 1)'(usq) << 28;
    if (sum <= rhs) begin
      r.p = sum[NP_W-1:0];
      r.q = s.q + (NQ_W'(dd) << NBIT);
      r.k = s.k | (NK_W'(1) << NBIT);
    end
    return r;
  endfunction

  always_comb begin
    stage_nxt = d_in;
    trial     = (SQ_W + 1)'(d_in.res) + ((SQ_W + 1)'(1) << RBIT);
    if ((SQ_W + 1)'(d_in.rad) >= trial) begin
      stage_nxt.rad = d_in.rad - trial[SQ_W-1:0];
      stage_nxt.res = (d_in.res >> 1) + (SQ_W'(1) << RBIT);
    end else begin
      stage_nxt.res = d_in.res >> 1;
    end
    if (STEP < NORM_STEPS) begin
      stage_nxt.nx = nrm_step(d_in.nx, d_in.dd, d_in.usq_x);
      stage_nxt.ny = nrm_step(d_in.ny, d_in.dd, d_in.usq_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign d_out = stage_r;

endmodule

[rtl/cpt_div_stage.sv]
// One restoring-division stage of the contact time quotient.
module cpt_div_stage #(
  parameter int STEP = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  cpt_pkg::div_t d_in,
  output cpt_pkg::div_t d_out
);
  import cpt_pkg::*;

  localparam int DBIT = DIV_STEPS - 1 - STEP;

  div_t             stage_r, stage_nxt;
  logic [CMP_W-1:0] shifted_den;
  logic [CMP_W-1:0] rem_ext;

  always_comb begin
    stage_nxt   = d_in;
    shifted_den = CMP_W'(d_in.den) << DBIT;
    rem_ext     = CMP_W'(d_in.rem);
    if (rem_ext >= shifted_den) begin
      stage_nxt.rem = REM_W'(rem_ext - shifted_den);
      stage_nxt.t   = d_in.t | (TW'(1) << DBIT);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r.valid <= 1'b0;
    end else if (en) begin
      stage_r <= stage_nxt;
    end
  end

  assign d_out = stage_r;

endmodule

[rtl/circle_point_time_of_impact.sv]
// Top level of the circle/point time-of-impact pipeline.
//
// Each request on in_chan is one moving circle (centre, velocity) and one fixed
// point, all signed Q16.16. For every request the block returns exactly one
// result on out_chan: a status code, the time to contact, the unit normal
// (Q2.14) and the contact point. Results leave in request order.
// The radius shared by all circles is written through cfg_chan, which is
// always ready; it should only be changed while no request is in flight.
//
// From acceptance to the result register a request passes the coefficient
// stages, the discriminant stages, 65 square-root digit stages (the first 15
// also resolve the normal), one set-up stage and 31 quotient stages, then the
// output register. A new request is taken every cycle unless out_chan stalls.
//
// Reset clears the radius to 1.0 and empties the pipeline. When the receiver
// holds out_chan.ready low with a result waiting, the whole pipeline freezes
// and in_chan.ready drops in the same cycle; nothing is dropped or repeated.
module circle_point_time_of_impact #(
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  cpt_chan_if.sink      in_chan,
  cpt_chan_if.source    out_chan,
  cpt_chan_if.sink      cfg_chan
);
  import cpt_pkg::*;

  logic        en;
  logic [30:0] radius_r;
  logic        out_valid_r;
  out_item_t   out_data_r, out_data_nxt;

  coef_t       coef;
  root_t       root_q [ROOT_STEPS+1];
  div_t        div_q  [DIV_STEPS+1];
  prep_t       prep_r, prep_nxt;

  logic [DD_W:0]    twice_m_less_s;
  logic [CMP_W-1:0] den_ext;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_chan.valid) begin
      radius_r <= cfg_chan.data;
    end
  end

  cpt_coef u_coef (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .item_valid (in_chan.valid),
    .item       (in_chan.data),
    .radius     (radius_r),
    .coef       (coef)
  );

  cpt_disc u_disc (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .coef  (coef),
    .root  (root_q[0])
  );

  for (genvar i = 0; i < ROOT_STEPS; i++) begin : g_root
    cpt_root_stage #(.STEP(i)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (root_q[i]),
      .d_out (root_q[i+1])
    );
  end

  // Set-up: numerator (2m - s) scaled by the fraction bits, and the saturation
  // limit 2a * TMAX.
  always_comb begin
    twice_m_less_s   = {root_q[ROOT_STEPS].m, 1'b0}
                     - (DD_W + 1)'(root_q[ROOT_STEPS].res[DD_W-1:0]);
    den_ext          = CMP_W'({root_q[ROOT_STEPS].a, 1'b0});
    prep_nxt         = '0;
    prep_nxt.valid   = root_q[ROOT_STEPS].valid;
    prep_nxt.status  = root_q[ROOT_STEPS].status;
    prep_nxt.num     = REM_W'(twice_m_less_s) << COORD_FRAC_BITS;
    prep_nxt.den     = {root_q[ROOT_STEPS].a, 1'b0};
    prep_nxt.lim     = (den_ext << TW) - den_ext;
    prep_nxt.dd_zero = (root_q[ROOT_STEPS].dd == '0);
    prep_nxt.kx      = root_q[ROOT_STEPS].nx.k;
    prep_nxt.ky      = root_q[ROOT_STEPS].ny.k;
    prep_nxt.sx      = root_q[ROOT_STEPS].sx;
    prep_nxt.sy      = root_q[ROOT_STEPS].sy;
    prep_nxt.tx      = root_q[ROOT_STEPS].tx;
    prep_nxt.ty      = root_q[ROOT_STEPS].ty;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prep_r.valid <= 1'b0;
    end else if (en) begin
      prep_r <= prep_nxt;
    end
  end

  always_comb begin
    div_q[0]         = '0;
    div_q[0].valid   = prep_r.valid;
    div_q[0].status  = prep_r.status;
    div_q[0].rem     = prep_r.num;
    div_q[0].den     = prep_r.den;
    div_q[0].sat     = (CMP_W'(prep_r.num) >= prep_r.lim);
    div_q[0].dd_zero = prep_r.dd_zero;
    div_q[0].kx      = prep_r.kx;
    div_q[0].ky      = prep_r.ky;
    div_q[0].sx      = prep_r.sx;
    div_q[0].sy      = prep_r.sy;
    div_q[0].tx      = prep_r.tx;
    div_q[0].ty      = prep_r.ty;
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    cpt_div_stage #(.STEP(j)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_in  (div_q[j]),
      .d_out (div_q[j+1])
    );
  end

  // Result assembly: every field but the status is zero unless the circle hits.
  always_comb begin
    out_data_nxt        = '0;
    out_data_nxt.status = div_q[DIV_STEPS].status;
    if (div_q[DIV_STEPS].status == ST_HIT) begin
      out_data_nxt.time_to_contact = div_q[DIV_STEPS].sat ? TMAX : div_q[DIV_STEPS].t;
      out_data_nxt.contact_x       = div_q[DIV_STEPS].tx;
      out_data_nxt.contact_y       = div_q[DIV_STEPS].ty;
      if (!div_q[DIV_STEPS].dd_zero) begin
        out_data_nxt.normal_x = div_q[DIV_STEPS].sx ? -16'(div_q[DIV_STEPS].kx)
                                                    : 16'(div_q[DIV_STEPS].kx);
        out_data_nxt.normal_y = div_q[DIV_STEPS].sy ? -16'(div_q[DIV_STEPS].ky)
                                                    : 16'(div_q[DIV_STEPS].ky);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_q[DIV_STEPS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  a_non_hit_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_HIT |->
      out_data_r.time_to_contact == '0 && out_data_r.normal_x == '0 &&
      out_data_r.normal_y == '0 && out_data_r.contact_x == '0 &&
      out_data_r.contact_y == '0)
    else $error("non-hit result carries nonzero fields");

  a_normal_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status == ST_HIT |->
      out_data_r.normal_x <= 16'sd16384 && out_data_r.normal_x >= -16'sd16384 &&
      out_data_r.normal_y <= 16'sd16384 && out_data_r.normal_y >= -16'sd16384)
    else $error("normal component exceeds unit length");

  a_frozen_tail : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(div_q[DIV_STEPS].valid) && $stable(div_q[DIV_STEPS].t))
    else $error("pipeline tail moved during a stall");

endmodule
